>>> rtl/core/stereo_nearest_feature_matcher_assert.svh
// Assertion macros for the stereo matcher RTL.
// Needs nothing else; pulled in by snfm_ctrl, the module that carries checks.
`ifndef STEREO_NEAREST_FEATURE_MATCHER_ASSERT_SVH
`define STEREO_NEAREST_FEATURE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snfm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SNFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snfm check failed");

`endif

>>> rtl/core/snfm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the stereo matcher.
// Standalone; used by every file of the block but snfm_ram and the assertion header.
package snfm_pkg;

    localparam int MAX_RIGHT_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF       = 12;

    localparam int ROW_TOL_W = 12;
    localparam int IDX_W     = 6;
    localparam int DIST_W    = 25;

    localparam logic [ROW_TOL_W-1:0] ROW_TOL_RESET = 12'd9;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Word index of each register (paddr above the byte bits).
    localparam logic [APB_AW-3:0] REG_ROW_TOL = '0;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic start_query;
        logic wr_en;
        logic rd_en;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/core/snfm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input words and result words.
// Depends on snfm_pkg for default widths.
interface snfm_in_if #(
    parameter int COORD_BITS = snfm_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic                  first_of_frame;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, kind, first_of_frame, point_x, point_y, input ready);
    modport sink   (input valid, kind, first_of_frame, point_x, point_y, output ready);
endinterface

interface snfm_out_if ();
    import snfm_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] distance_squared;

    modport source (output valid, found, match_index, distance_squared, input ready);
    modport sink   (input valid, found, match_index, distance_squared, output ready);
endinterface

>>> rtl/core/snfm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module snfm_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/core/snfm_ctrl.sv
`timescale 1ns / 1ps
// Controller: input handshake, store fill count, scan sequencing.
// Depends on snfm_pkg, snfm_if and the assertion macro header.
`include "stereo_nearest_feature_matcher_assert.svh"
module snfm_ctrl #(
    parameter int MAX_RIGHT_POINTS = snfm_pkg::MAX_RIGHT_POINTS_DEF,
    parameter int ADDR_W = (MAX_RIGHT_POINTS > 1) ? $clog2(MAX_RIGHT_POINTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    snfm_in_if.sink              i_in,
    output snfm_pkg::t_dp_cmd    o_cmd,
    output logic [ADDR_W-1:0]    o_addr,
    input  snfm_pkg::t_dp_status i_status
);
    import snfm_pkg::*;

    localparam int CNT_W = $clog2(MAX_RIGHT_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RIGHT_POINTS);

    t_ctrl_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan,  n_scan;
    logic             in_fire;

    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan     = r_scan;
        o_cmd      = '0;
        o_addr     = '0;
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.kind == KIND_STORE) begin
                        // restart the frame, or append while there is room
                        if (i_in.first_of_frame) begin
                            o_cmd.wr_en = 1'b1;
                            n_count     = CNT_W'(1);
                        end else if (r_count < CNT_MAX) begin
                            o_cmd.wr_en = 1'b1;
                            o_addr      = r_count[ADDR_W-1:0];
                            n_count     = r_count + CNT_W'(1);
                        end
                    end else begin
                        o_cmd.start_query = 1'b1;
                        n_scan            = '0;
                        n_state           = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan == r_count) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_addr      = r_scan[ADDR_W-1:0];
                    n_scan      = r_scan + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SNFM_ASSERT_NEXT(a_query_starts_scan, i_clk, i_rst_n,
        in_fire && i_in.kind == KIND_QUERY, r_state == ST_SCAN && r_scan == '0)
    `SNFM_ASSERT_NOW(a_read_inside_store, i_clk, i_rst_n,
        o_cmd.rd_en, r_scan < r_count && r_count <= CNT_MAX)
    `SNFM_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n,
        in_fire && i_in.kind == KIND_STORE && i_in.first_of_frame, r_count == CNT_W'(1))
endmodule

>>> rtl/core/snfm_dp.sv
`timescale 1ns / 1ps
// Datapath: point store RAM, distance pipeline, best-match tracker, result register.
// Depends on snfm_pkg, snfm_if and snfm_ram.
module snfm_dp #(
    parameter int MAX_RIGHT_POINTS = snfm_pkg::MAX_RIGHT_POINTS_DEF,
    parameter int COORD_BITS       = snfm_pkg::COORD_BITS_DEF,
    parameter int ADDR_W = (MAX_RIGHT_POINTS > 1) ? $clog2(MAX_RIGHT_POINTS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  snfm_pkg::t_dp_cmd                 i_cmd,
    input  logic [ADDR_W-1:0]                 i_addr,
    input  logic [COORD_BITS-1:0]             i_point_x,
    input  logic [COORD_BITS-1:0]             i_point_y,
    input  logic [snfm_pkg::ROW_TOL_W-1:0]    i_row_tol,
    output snfm_pkg::t_dp_status              o_status,
    snfm_out_if.source                        o_out
);
    import snfm_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = 2 * COORD_BITS + 1;
    localparam int CMP_W = (COORD_BITS > ROW_TOL_W) ? COORD_BITS : ROW_TOL_W;

    logic [COORD_BITS-1:0] r_qx, r_qy;
    logic [SQ_W-1:0]       rd_data;
    logic [COORD_BITS-1:0] sx, sy, dx, dy;
    logic                  row_ok;

    logic                  r_v0, r_v1, r_v2;
    logic [ADDR_W-1:0]     r_idx0, r_idx1, r_idx2;
    logic [COORD_BITS-1:0] r_dx1, r_dy1;
    logic [SQ_W-1:0]       r_sqx2, r_sqy2;

    logic [SUM_W-1:0]      sum_sq;
    logic                  better;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_best_idx;
    logic [SUM_W-1:0]      r_best_dist;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_idx;
    logic [DIST_W-1:0]     r_out_dist;

    snfm_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_RIGHT_POINTS),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_addr),
        .i_wr_data({i_point_y, i_point_x}),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_addr),
        .o_rd_data(rd_data)
    );

    // stage 1: absolute differences and row window
    assign sx     = rd_data[COORD_BITS-1:0];
    assign sy     = rd_data[SQ_W-1:COORD_BITS];
    assign dx     = (r_qx >= sx) ? r_qx - sx : sx - r_qx;
    assign dy     = (r_qy >= sy) ? r_qy - sy : sy - r_qy;
    assign row_ok = CMP_W'(dy) <= CMP_W'(i_row_tol);

    // stage 3: sum and keep the first smallest
    assign sum_sq = SUM_W'(r_sqx2) + SUM_W'(r_sqy2);
    assign better = !r_found || (sum_sq < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd_en;
            r_v1 <= r_v0 && row_ok;
            r_v2 <= r_v1;
            if (i_cmd.start_query) begin
                r_found <= 1'b0;
            end else if (r_v2 && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_qx <= i_point_x;
            r_qy <= i_point_y;
        end
        r_idx0 <= i_addr;
        r_idx1 <= r_idx0;
        r_dx1  <= dx;
        r_dy1  <= dy;
        r_idx2 <= r_idx1;
        r_sqx2 <= SQ_W'(r_dx1) * SQ_W'(r_dx1);
        r_sqy2 <= SQ_W'(r_dy1) * SQ_W'(r_dy1);
        if (r_v2 && better) begin
            r_best_idx  <= r_idx2;
            r_best_dist <= sum_sq;
        end
        if (i_cmd.load_out) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? IDX_W'(r_best_idx) : '0;
            r_out_dist  <= r_found ? DIST_W'(r_best_dist) : '0;
        end
    end

    assign o_status.pipe_busy = r_v0 || r_v1 || r_v2;
    assign o_status.out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid            = r_out_valid;
    assign o_out.found            = r_out_found;
    assign o_out.match_index      = r_out_idx;
    assign o_out.distance_squared = r_out_dist;
endmodule

>>> rtl/core/stereo_nearest_feature_matcher.sv
`timescale 1ns / 1ps
// Stereo nearest-feature matcher. Input words on i_in (valid/ready), result
// words on o_out (valid/ready), row tolerance register on an APB-style port.
// A store word (kind 0) appends a right-image point to the on-chip store
// as it is accepted; first_of_frame empties the store first. Stores past
// capacity are dropped. No result word is produced for a store.
// A query word (kind 1) scans the stored points one per cycle through a
// single RAM read port, skips points whose row difference exceeds
// row_tolerance and returns found, index and squared distance of the
// nearest one (earliest index on a tie). After acceptance the controller
// steps through scan, drain and done before loading the result register;
// the drain ends early when the last points fall outside the row window.
// The RAM read port sets the one-point-per-cycle pace. i_in accepts only
// while the controller is idle, so no word is taken until a query is loaded.
// The result register holds its word until taken; the next query may start
// while it waits and only stalls at its end if o_out is still held.
// Reset (synchronous, active low) empties the store, sets row_tolerance to 9
// and clears any pending result. Store contents need no clearing pass.
// Depends on snfm_pkg, snfm_if, snfm_ctrl, snfm_dp, snfm_ram.
module stereo_nearest_feature_matcher #(
    parameter int MAX_RIGHT_POINTS = snfm_pkg::MAX_RIGHT_POINTS_DEF,
    parameter int COORD_BITS       = snfm_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    snfm_in_if.sink                       i_in,
    snfm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [snfm_pkg::APB_AW-1:0]   paddr,
    input  logic [snfm_pkg::APB_DW-1:0]   pwdata,
    output logic [snfm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import snfm_pkg::*;

    localparam int ADDR_W = (MAX_RIGHT_POINTS > 1) ? $clog2(MAX_RIGHT_POINTS) : 1;

    logic [ROW_TOL_W-1:0] r_row_tol;
    logic                 cfg_wr;
    logic                 sel_row_tol;
    t_dp_cmd              cmd;
    t_dp_status           status;
    logic [ADDR_W-1:0]    addr;

    // Register decode: word index sits above the two byte-offset bits.
    assign sel_row_tol = (paddr[APB_AW-1:2] == REG_ROW_TOL);
    assign cfg_wr      = psel && penable && pwrite && pready && sel_row_tol;
    assign pready      = 1'b1;
    assign prdata      = sel_row_tol ? APB_DW'(r_row_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_tol <= ROW_TOL_RESET;
        end else if (cfg_wr) begin
            r_row_tol <= pwdata[ROW_TOL_W-1:0];
        end
    end

    // Controller owns the handshake, fill count and scan address.
    snfm_ctrl #(
        .MAX_RIGHT_POINTS(MAX_RIGHT_POINTS),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (cmd),
        .o_addr  (addr),
        .i_status(status)
    );

    // Datapath holds the store, the distance pipeline and the result word.
    snfm_dp #(
        .MAX_RIGHT_POINTS(MAX_RIGHT_POINTS),
        .COORD_BITS      (COORD_BITS),
        .ADDR_W          (ADDR_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_addr   (addr),
        .i_point_x(i_in.point_x),
        .i_point_y(i_in.point_y),
        .i_row_tol(r_row_tol),
        .o_status (status),
        .o_out    (o_out)
    );
endmodule

>>> dv/snfm_match_checker.sv
`timescale 1ns / 1ps
// Match checker for the stereo matcher: mirrors the point store and row tolerance,
// predicts each query result and compares it with the words on the result channel.
// Depends on snfm_pkg.
module snfm_match_checker
    import snfm_pkg::*;
#(
    parameter int POINT_CAP  = MAX_RIGHT_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_in_kind,
    input  logic                  i_in_first,
    input  logic [COORD_BITS-1:0] i_in_x,
    input  logic [COORD_BITS-1:0] i_in_y,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_out_found,
    input  logic [IDX_W-1:0]      i_out_index,
    input  logic [DIST_W-1:0]     i_out_dist,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_results,
    output int                    o_matched
);

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  match_index;
        logic [DIST_W-1:0] distance_squared;
    } t_match;

    logic [COORD_BITS-1:0] right_x [POINT_CAP];
    logic [COORD_BITS-1:0] right_y [POINT_CAP];
    int                    right_count;
    logic [ROW_TOL_W-1:0]  row_tol;
    t_match                pending_matches [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_results     = 0;
        o_matched     = 0;
        right_count   = 0;
        row_tol       = ROW_TOL_RESET;
    end

    function automatic int unsigned coord_gap(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
        return (a >= b) ? 32'(a) - 32'(b) : 32'(b) - 32'(a);
    endfunction

    // Nearest stored right point within the row band; earliest index wins a tie.
    function automatic t_match nearest_right_point(input logic [COORD_BITS-1:0] qx,
                                                   input logic [COORD_BITS-1:0] qy);
        t_match      best;
        int unsigned dx;
        int unsigned dy;
        int unsigned d;
        int          j;
        best = '0;
        for (j = 0; j < right_count; j++) begin
            dy = coord_gap(qy, right_y[j]);
            if (dy > 32'(row_tol)) continue;
            dx = coord_gap(qx, right_x[j]);
            d  = dx * dx + dy * dy;
            if (!best.found || d < 32'(best.distance_squared)) begin
                best.found            = 1'b1;
                best.match_index      = IDX_W'(j);
                best.distance_squared = DIST_W'(d);
            end
        end
        return best;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s at %0t: got %0d, want %0d", what, $realtime, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            right_count = 0;
            row_tol     = ROW_TOL_RESET;
            pending_matches.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_AW-1:2] == REG_ROW_TOL) begin
                row_tol = i_pwdata[ROW_TOL_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (i_out_found) o_matched++;
                if (pending_matches.size() == 0) begin
                    flag_mismatch("result with no query waiting", i_out_found, 0);
                end else begin
                    want = pending_matches.pop_front();
                    if (i_out_found !== want.found)
                        flag_mismatch("found", i_out_found, want.found);
                    if (i_out_index !== want.match_index)
                        flag_mismatch("match_index", i_out_index, want.match_index);
                    if (i_out_dist !== want.distance_squared)
                        flag_mismatch("distance_squared", i_out_dist,
                                      want.distance_squared);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_kind == KIND_STORE) begin
                    if (i_in_first) right_count = 0;
                    if (right_count < POINT_CAP) begin
                        right_x[right_count] = i_in_x;
                        right_y[right_count] = i_in_y;
                        right_count++;
                    end
                end else begin
                    pending_matches.insert(pending_matches.size(),
                                           nearest_right_point(i_in_x, i_in_y));
                end
            end
        end
        o_outstanding = pending_matches.size();
    end

endmodule

>>> dv/stereo_nearest_feature_matcher_test.sv
`timescale 1ns / 1ps
// Top of the stereo matcher testbench: clock, reset, stimulus, register writes
// and verdict. Depends on snfm_pkg, snfm_if, the matcher RTL and snfm_match_checker.
module stereo_nearest_feature_matcher_test;
    import snfm_pkg::*;

    localparam int COORD_MAX      = (1 << COORD_BITS_DEF) - 1;
    localparam int TOL_MAX        = (1 << ROW_TOL_W) - 1;
    localparam int POINT_CAP      = MAX_RIGHT_POINTS_DEF;
    localparam int WORD_TARGET    = 1700;
    localparam int PHASE_WORDS    = 170;
    // Covers the longest query over a full store, with a margin on top.
    localparam int DRAIN_CYCLES   = POINT_CAP + 16;
    localparam int HOLDOFF_CYCLES = 500;
    localparam int STALL_LIMIT    = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    snfm_in_if  in_ch ();
    snfm_out_if out_ch ();

    int mismatches;
    int outstanding;
    int results_seen;
    int matches_seen;
    int words_sent;
    int settings_done;
    int tol_now;
    int phase;
    int phase_start;

    // Steady phase: neither side idles.
    bit steady;
    // Each bump asks the result side for one long hold-off.
    int holdoff_asked;
    int holdoff_served;

    // Stimulus-side copy of the current frame, used only to aim queries.
    int frame_x [POINT_CAP];
    int frame_y [POINT_CAP];
    int frame_count;

    stereo_nearest_feature_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    snfm_match_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_kind     (in_ch.kind),
        .i_in_first    (in_ch.first_of_frame),
        .i_in_x        (in_ch.point_x),
        .i_in_y        (in_ch.point_y),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_found   (out_ch.found),
        .i_out_index   (out_ch.match_index),
        .i_out_dist    (out_ch.distance_squared),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results_seen),
        .o_matched     (matches_seen)
    );

    // 12 ns clock, first rising edge at 6 ns.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Clamp a coordinate into the field range.
    function automatic int clip_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Random coordinate within +/- span of center, clamped.
    function automatic int jitter(input int center, input int span);
        return clip_coord(center + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Offer one input word and hold it until accepted; return at a falling edge.
    // valid stays high between back-to-back words and is only lowered for a gap.
    task automatic send_word(input logic kind, input logic first, input int x, input int y);
        int gap;
        if (!steady && $urandom_range(0, 99) < 33) begin
            gap = $urandom_range(1, 3);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.kind           = kind;
        in_ch.first_of_frame = first;
        in_ch.point_x        = x[COORD_BITS_DEF-1:0];
        in_ch.point_y        = y[COORD_BITS_DEF-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        words_sent++;
        // Track the frame for aiming later queries; drop stores past capacity.
        if (kind == KIND_STORE) begin
            if (first) frame_count = 0;
            if (frame_count < POINT_CAP) begin
                frame_x[frame_count] = x;
                frame_y[frame_count] = y;
                frame_count++;
            end
        end
    endtask

    // Drop valid, wait for every result, then let a store or query in flight finish.
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic write_reg(input logic [APB_AW-3:0] index, input logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_tolerance(input int t);
        wait_idle();
        write_reg(REG_ROW_TOL, t);
        tol_now = t;
        settings_done++;
    endtask

    // One frame: a run of right points around a random row band, then queries
    // aimed mostly at stored points and inside the band, with some noise.
    task automatic run_frame();
        int   n;
        int   base_x;
        int   base_y;
        int   spread;
        int   reach;
        int   i;
        int   j;
        int   q;
        int   x;
        logic first;
        case ($urandom_range(0, 9))
            7, 8:    n = $urandom_range(13, 40);
            9:       n = $urandom_range(POINT_CAP - 4, POINT_CAP + 6);
            default: n = $urandom_range(1, 12);
        endcase
        base_x = $urandom_range(0, COORD_MAX);
        base_y = $urandom_range(0, COORD_MAX);
        spread = $urandom_range(0, 48);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) x = $urandom_range(0, COORD_MAX);
            else x = jitter(base_x, 200);
            // Now and then continue the previous frame instead of starting fresh.
            first = (i == 0) && ($urandom_range(0, 19) != 0);
            send_word(KIND_STORE, first, x, jitter(base_y, spread));
        end
        reach = ((tol_now < 200) ? tol_now : 200) + 2;
        q = $urandom_range(1, 10);
        for (i = 0; i < q; i++) begin
            case ($urandom_range(0, 19))
                0: send_word(KIND_STORE, 1'b0, $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX));
                1, 2, 3, 4: send_word(KIND_QUERY, 1'($urandom_range(0, 1)),
                                      $urandom_range(0, COORD_MAX),
                                      $urandom_range(0, COORD_MAX));
                default: begin
                    j = $urandom_range(0, frame_count - 1);
                    send_word(KIND_QUERY, ($urandom_range(0, 9) == 0),
                              jitter(frame_x[j], 50), jitter(frame_y[j], reach));
                end
            endcase
        end
    endtask

    // Result side: random ready, steady in the steady phase, and long hold-offs
    // on request so the result register and the query behind it back up.
    initial begin
        out_ch.ready   = 1'b0;
        holdoff_served = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_asked != holdoff_served) begin
                holdoff_served = holdoff_asked;
                out_ch.ready   = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            out_ch.ready = steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = KIND_STORE;
        in_ch.first_of_frame = 1'b0;
        in_ch.point_x        = '0;
        in_ch.point_y        = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        steady               = 1'b0;
        holdoff_asked        = 0;
        words_sent           = 0;
        settings_done        = 0;
        frame_count          = 0;
        tol_now              = ROW_TOL_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset tolerance.
        // Query an empty store, once with the frame flag set on the query.
        send_word(KIND_QUERY, 1'b0, 0, 0);
        send_word(KIND_QUERY, 1'b1, COORD_MAX, COORD_MAX);
        // Equal distances and a duplicate point: the earliest index must win.
        send_word(KIND_STORE, 1'b1, 100, 100);
        send_word(KIND_STORE, 1'b0, 102, 100);
        send_word(KIND_STORE, 1'b0, 100, 100);
        send_word(KIND_QUERY, 1'b0, 101, 100);
        send_word(KIND_QUERY, 1'b0, 100, 100);
        // Row difference right at the tolerance, one past it, and at it from below.
        send_word(KIND_QUERY, 1'b0, 100, 109);
        send_word(KIND_QUERY, 1'b0, 100, 110);
        send_word(KIND_QUERY, 1'b0, 100, 91);
        // Corner points of the image.
        send_word(KIND_STORE, 1'b1, 0, 0);
        send_word(KIND_STORE, 1'b0, COORD_MAX, COORD_MAX);
        send_word(KIND_STORE, 1'b0, 0, COORD_MAX);
        send_word(KIND_STORE, 1'b0, COORD_MAX, 0);
        send_word(KIND_QUERY, 1'b0, COORD_MAX, COORD_MAX);
        send_word(KIND_QUERY, 1'b0, 0, 4);
        send_word(KIND_QUERY, 1'b1, 2048, 2048);
        // Widest tolerance: largest possible squared distance.
        set_tolerance(TOL_MAX);
        send_word(KIND_STORE, 1'b1, 0, 0);
        send_word(KIND_QUERY, 1'b0, COORD_MAX, COORD_MAX);
        send_word(KIND_QUERY, 1'b0, 2048, 2048);

        // Random part, one tolerance setting per phase.
        for (phase = 0; words_sent < WORD_TARGET; phase++) begin
            case (phase)
                0: set_tolerance(0);
                1: set_tolerance(1);
                2: set_tolerance(TOL_MAX);
                default: begin
                    if ($urandom_range(0, 3) == 0) set_tolerance($urandom_range(0, TOL_MAX));
                    else set_tolerance($urandom_range(0, 40));
                end
            endcase
            steady = (phase == 3);
            // Hold the result side off while words keep coming.
            if (phase == 4) holdoff_asked++;
            phase_start = words_sent;
            while (words_sent < phase_start + PHASE_WORDS) run_frame();
        end
        steady = 1'b0;

        wait_idle();
        $display("covered %0d input words over %0d register settings", words_sent,
                 settings_done);
        $display("checked %0d results, %0d with a match", results_seen, matches_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
